@@ sv/htfr_pkg.sv @@
package htfr_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END    = 1'd1;

	localparam int CFG_DATA_W = 8;
	localparam int BYTE_W     = 8;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd100;
	localparam logic [BYTE_W-1:0] END_RESET    = 8'd102;

	localparam int DEPTH_DEFAULT = 256;

	// Per-item status flags handed from the control logic to the pipeline.
	typedef struct packed {
		logic done;
		logic open;
		logic ovf;
		logic rd_ok;
	} status_t;

endpackage

@@ sv/htfr_if.sv @@
interface htfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, req_type, rx_byte, read_index, input ready);
	modport sink   (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface htfr_out_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic       in_frame;
	logic [7:0] frame_length;
	logic [7:0] read_data;
	logic       overflowed;

	modport source (output valid, frame_done, in_frame, frame_length, read_data, overflowed,
		input ready);
	modport sink   (input valid, frame_done, in_frame, frame_length, read_data, overflowed,
		output ready);
endinterface

@@ sv/header_terminator_frame_receiver.sv @@
// Frame receiver for byte streams delimited by a header byte and an end byte. Each input
// item is a received byte, a read of the stored frame at an index, or a release that clears
// the frame status, and each item yields exactly one result carrying the status after the
// item plus the read byte (zero when out of range or not a read). An item is accepted every
// cycle unless the output stalls; its result is held first in the control update and
// registered frame memory read stage, then the output register, which lets a new item enter
// while a result waits to be taken. The frame memory holds DEPTH bytes and needs no clearing
// after reset, since only positions written in the current frame are ever read back.
module header_terminator_frame_receiver #(
	parameter int DEPTH = htfr_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [htfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [htfr_pkg::CFG_DATA_W-1:0] cfg_data,
	htfr_in_if.sink                        in_ch,
	htfr_out_if.source                     out_ch
);
	import htfr_pkg::*;

	localparam int LEN_W = $clog2(DEPTH);

	logic              accept;
	logic              mem_we;
	logic [LEN_W-1:0]  mem_waddr;
	logic              mem_re;
	logic [LEN_W-1:0]  mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	status_t           status;
	logic [LEN_W-1:0]  len_next;

	logic              valid_s1;
	status_t           status_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              adv_s1;

	logic              valid_q;
	logic              done_q;
	logic              open_q;
	logic [7:0]        length_q;
	logic [BYTE_W-1:0] rdata_q;
	logic              ovf_q;

	assign adv_s1      = valid_s1 && (!valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign accept      = in_ch.valid && in_ch.ready;

	htfr_ctrl #(
		.DEPTH (DEPTH),
		.LEN_W (LEN_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.req_type   (in_ch.req_type),
		.rx_byte    (in_ch.rx_byte),
		.read_index (in_ch.read_index),
		.we         (mem_we),
		.waddr      (mem_waddr),
		.re         (mem_re),
		.raddr      (mem_raddr),
		.status     (status),
		.len_next   (len_next)
	);

	htfr_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (LEN_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_ch.rx_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			len_s1    <= len_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_s1) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			done_q   <= status_s1.done;
			open_q   <= status_s1.open;
			length_q <= 8'(len_s1);
			rdata_q  <= status_s1.rd_ok ? mem_rdata : '0;
			ovf_q    <= status_s1.ovf;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.frame_done   = done_q;
	assign out_ch.in_frame     = open_q;
	assign out_ch.frame_length = length_q;
	assign out_ch.read_data    = rdata_q;
	assign out_ch.overflowed   = ovf_q;
endmodule

@@ sv/htfr_store.sv @@
module htfr_store #(
	parameter int DEPTH = htfr_pkg::DEPTH_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [htfr_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [htfr_pkg::BYTE_W-1:0] rdata
);
	import htfr_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/htfr_ctrl.sv @@
module htfr_ctrl #(
	parameter int DEPTH = htfr_pkg::DEPTH_DEFAULT,
	parameter int LEN_W = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [htfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [htfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	input  logic [1:0]                     req_type,
	input  logic [htfr_pkg::BYTE_W-1:0]     rx_byte,
	input  logic [7:0]                     read_index,
	output logic                           we,
	output logic [LEN_W-1:0]               waddr,
	output logic                           re,
	output logic [LEN_W-1:0]               raddr,
	output htfr_pkg::status_t              status,
	output logic [LEN_W-1:0]               len_next
);
	import htfr_pkg::*;

	localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] end_q;
	logic              done_q;
	logic              open_q;
	logic [LEN_W-1:0]  len_q;

	logic done_d;
	logic open_d;
	logic wr_d;
	logic [LEN_W-1:0] waddr_d;

	always_comb begin
		done_d   = done_q;
		open_d   = open_q;
		len_next = len_q;
		wr_d     = 1'b0;
		waddr_d  = '0;
		status   = '0;
		unique case (req_type)
			REQ_BYTE: begin
				if (!done_q) begin
					if (open_q && rx_byte == end_q) begin
						done_d = 1'b1;
					end else if (rx_byte == header_q) begin
						wr_d     = 1'b1;
						waddr_d  = '0;
						len_next = LEN_W'(1);
						open_d   = 1'b1;
					end else if (open_q) begin
						wr_d    = 1'b1;
						waddr_d = len_q;
						// The append that would reach DEPTH-1 throws the frame away.
						if (len_q == LEN_W'(DEPTH - 2)) begin
							done_d     = 1'b0;
							open_d     = 1'b0;
							len_next   = '0;
							status.ovf = 1'b1;
						end else begin
							len_next = len_q + 1'b1;
						end
					end
				end
			end
			REQ_READ: begin
				// The length never reaches DEPTH, so this also keeps the index in range.
				status.rd_ok = CMP_W'(read_index) < CMP_W'(len_q);
			end
			REQ_RELEASE: begin
				done_d   = 1'b0;
				open_d   = 1'b0;
				len_next = '0;
			end
			default: begin
			end
		endcase
		status.done = done_d;
		status.open = open_d;
	end

	assign we    = accept && wr_d;
	assign waddr = waddr_d;
	assign re    = accept && (req_type == REQ_READ);
	assign raddr = LEN_W'(read_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			open_q <= 1'b0;
			len_q  <= '0;
		end else if (accept) begin
			done_q <= done_d;
			open_q <= open_d;
			len_q  <= len_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			end_q    <= END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER: header_q <= cfg_data;
				CFG_END:    end_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end
endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import htfr_pkg::*;

	localparam int FRAME_DEPTH  = DEPTH_DEFAULT;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        req;
		logic [BYTE_W-1:0] rx;
		logic [BYTE_W-1:0] idx;
	} rx_item_t;

	typedef struct packed {
		logic              frame_done;
		logic              in_frame;
		logic [7:0]        frame_length;
		logic [BYTE_W-1:0] read_data;
		logic              overflowed;
	} frame_status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	htfr_in_if  in_ch();
	htfr_out_if out_ch();

	header_terminator_frame_receiver #(.DEPTH(FRAME_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	rx_item_t      pending_items[$];
	frame_status_t predicted_status[$];
	int            items_queued;
	int            items_accepted;
	int            mismatches;
	int            quiet_cycles;
	int            send_idle_pct;
	int            stall_pct;
	bit            item_taken;

	// Predicted receiver state and delimiter settings.
	logic [BYTE_W-1:0] hdr_value;
	logic [BYTE_W-1:0] end_value;
	logic              rx_done;
	logic              rx_open;
	int                rx_length;
	logic [BYTE_W-1:0] rx_buffer [FRAME_DEPTH];

	function automatic frame_status_t advance_frame(rx_item_t it);
		frame_status_t r;
		r = '0;
		case (it.req)
			REQ_BYTE: begin
				if (!rx_done) begin
					// The end test comes first, so an end byte equal to the header closes an open frame.
					if (rx_open && it.rx == end_value) begin
						rx_done = 1'b1;
					end else if (it.rx == hdr_value) begin
						rx_buffer[0] = it.rx;
						rx_length = 1;
						rx_open = 1'b1;
					end else if (rx_open) begin
						if (rx_length < FRAME_DEPTH)
							rx_buffer[rx_length] = it.rx;
						rx_length++;
						if (rx_length >= FRAME_DEPTH - 1) begin
							rx_done = 1'b0;
							rx_open = 1'b0;
							rx_length = 0;
							r.overflowed = 1'b1;
						end
					end
				end
			end
			REQ_READ: begin
				if (int'(it.idx) < rx_length)
					r.read_data = rx_buffer[it.idx];
			end
			REQ_RELEASE: begin
				rx_done = 1'b0;
				rx_open = 1'b0;
				rx_length = 0;
			end
			default: begin
			end
		endcase
		r.frame_done = rx_done;
		r.in_frame = rx_open;
		r.frame_length = rx_length[7:0];
		return r;
	endfunction

	function automatic void queue_item(logic [1:0] req, logic [BYTE_W-1:0] b,
		logic [BYTE_W-1:0] idx);
		rx_item_t it;
		it = '{req: req, rx: b, idx: idx};
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_byte(logic [BYTE_W-1:0] b);
		queue_item(REQ_BYTE, b, BYTE_W'($urandom_range(255)));
	endfunction

	function automatic void queue_read(logic [BYTE_W-1:0] idx);
		queue_item(REQ_READ, BYTE_W'($urandom_range(255)), idx);
	endfunction

	function automatic void queue_release();
		queue_item(REQ_RELEASE, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
	endfunction

	// Frame content that is neither delimiter.
	function automatic logic [BYTE_W-1:0] rand_payload();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(255));
		while (b == hdr_value || b == end_value);
		return b;
	endfunction

	task automatic drain();
		while (items_accepted != items_queued || predicted_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_delimiters(logic [BYTE_W-1:0] h, logic [BYTE_W-1:0] e);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEADER;
		cfg_data <= h;
		hdr_value = h;
		@(negedge clk);
		cfg_index <= CFG_END;
		cfg_data <= e;
		end_value = e;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Header, the longest frame that still fits, reads at its edge, then the byte that
	// overflows it and a byte that must now be dropped.
	task automatic queue_overflow_frame();
		queue_byte(hdr_value);
		repeat (FRAME_DEPTH - 3) queue_byte(rand_payload());
		queue_read(8'h00);
		queue_read(BYTE_W'(FRAME_DEPTH - 3));
		queue_read(BYTE_W'(FRAME_DEPTH - 2));
		queue_read(BYTE_W'(FRAME_DEPTH - 1));
		queue_byte(rand_payload());
		queue_read(8'h00);
		queue_byte(rand_payload());
	endtask

	// Mostly well-formed frames with random content; the rest is random noise.
	// Stray bytes queued around each frame are not counted against n.
	task automatic queue_random_traffic(int n);
		int used;
		int len;
		int k;
		used = 0;
		while (used < n) begin
			if ($urandom_range(99) < 75) begin
				repeat ($urandom_range(0, 1)) queue_byte(rand_payload());
				queue_byte(hdr_value);
				len = 1;
				used++;
				k = $urandom_range(0, 10);
				repeat (k) begin
					if ($urandom_range(19) == 0) begin
						queue_byte(hdr_value);
						len = 1;
					end else if ($urandom_range(5) == 0) begin
						queue_read(BYTE_W'($urandom_range(0, len + 1)));
					end else begin
						queue_byte(rand_payload());
						len++;
					end
					used++;
				end
				if ($urandom_range(9) != 0) begin
					queue_byte(end_value);
					used++;
					repeat ($urandom_range(0, 2)) queue_byte(BYTE_W'($urandom_range(255)));
					repeat ($urandom_range(0, 3)) begin
						queue_read(BYTE_W'($urandom_range(0, len + 1)));
						used++;
					end
					if ($urandom_range(9) != 0) begin
						queue_release();
						used++;
					end
				end
			end else begin
				queue_item(2'($urandom_range(3)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)));
				used++;
			end
		end
	endtask

	task automatic run_phase(logic [BYTE_W-1:0] h, logic [BYTE_W-1:0] e, int send_idle,
		int stall, int n, bit with_overflow);
		drain();
		set_delimiters(h, e);
		send_idle_pct = send_idle;
		stall_pct = stall;
		if (with_overflow)
			queue_overflow_frame();
		queue_random_traffic(n);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Inputs change on the falling edge.
	always @(negedge clk) begin
		rx_item_t it;
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
		if (!in_ch.valid || item_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.req_type <= it.req;
				in_ch.rx_byte <= it.rx;
				in_ch.read_index <= it.idx;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Accepted items feed the predictor; accepted results are checked against it.
	always @(posedge clk) begin
		rx_item_t it;
		frame_status_t got;
		frame_status_t want;
		bit moved;
		moved = 1'b0;
		item_taken = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				it = '{req: in_ch.req_type, rx: in_ch.rx_byte, idx: in_ch.read_index};
				predicted_status.push_back(advance_frame(it));
				items_accepted++;
				item_taken = 1'b1;
				moved = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				got = '{frame_done: out_ch.frame_done, in_frame: out_ch.in_frame,
					frame_length: out_ch.frame_length, read_data: out_ch.read_data,
					overflowed: out_ch.overflowed};
				if (predicted_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: done=%0d open=%0d len=%0d data=%02h ovf=%0d",
							got.frame_done, got.in_frame, got.frame_length, got.read_data,
							got.overflowed);
				end else begin
					want = predicted_status.pop_front();
					if (got.frame_done !== want.frame_done || got.in_frame !== want.in_frame ||
						got.frame_length !== want.frame_length ||
						got.read_data !== want.read_data || got.overflowed !== want.overflowed) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected done=%0d open=%0d len=%0d data=%02h ovf=%0d,",
								" got done=%0d open=%0d len=%0d data=%02h ovf=%0d"},
								want.frame_done, want.in_frame, want.frame_length, want.read_data,
								want.overflowed, got.frame_done, got.in_frame, got.frame_length,
								got.read_data, got.overflowed);
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HEADER;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_BYTE;
		in_ch.rx_byte = '0;
		in_ch.read_index = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_queued = 0;
		items_accepted = 0;
		mismatches = 0;
		quiet_cycles = 0;
		hdr_value = HEADER_RESET;
		end_value = END_RESET;
		rx_done = 1'b0;
		rx_open = 1'b0;
		rx_length = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_delimiters(HEADER_RESET, END_RESET);
		// Bytes ahead of any header, including the end byte, are dropped.
		queue_byte(END_RESET);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_read(8'h00);
		queue_byte(HEADER_RESET);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h5A);
		queue_read(8'h00);
		queue_read(8'h02);
		queue_read(8'h03);
		queue_read(8'h04);
		queue_read(8'hFF);
		// A header in the middle of a frame restarts it.
		queue_byte(HEADER_RESET);
		queue_byte(8'hA5);
		queue_byte(END_RESET);
		// While a frame is held, even a header is ignored.
		queue_byte(HEADER_RESET);
		queue_byte(8'h33);
		queue_item(REQ_UNUSED, 8'hFF, 8'hFF);
		queue_read(8'h01);
		queue_release();
		queue_release();

		run_phase(8'h00, 8'hFF, 0, 0, 50, 1'b1);
		run_phase(8'hFF, 8'h00, 72, 0, 50, 1'b0);
		// Header and end byte share a value here.
		run_phase(8'h3C, 8'h3C, 0, 72, 50, 1'b0);
		run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 23, 23, 50,
			1'b0);
		run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 0, 0, 50,
			1'b0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_status.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
